// ===== rtl/core/ultrasonic_echo_ranging_core_assert.svh =====
// Assertion macros for the ranging core; clk and rst_n are taken from the enclosing module.
`ifndef ULTRASONIC_ECHO_RANGING_CORE_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGING_CORE_ASSERT_SVH

`ifndef SYNTH
`define UER_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UER_ASSERT_ALWAYS(label, expr, msg)
`define UER_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/uer_pkg.sv =====
`default_nettype none

package uer_pkg;

    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DIST_W   = 9;
    localparam int unsigned PERIOD_W = 22;
    localparam int unsigned DIV_W    = 16;

    typedef logic [DIST_W-1:0]   dist_t;
    typedef logic [PERIOD_W-1:0] period_t;
    typedef logic [DIV_W-1:0]    div_t;
    typedef logic [1:0]          reg_idx_t;

    localparam reg_idx_t REG_ENABLE       = 2'd0;
    localparam reg_idx_t REG_NOISE_THR    = 2'd1;
    localparam reg_idx_t REG_TRIG_PERIOD  = 2'd2;
    localparam reg_idx_t REG_TICKS_PER_CM = 2'd3;

    localparam dist_t   RST_NOISE_THR    = 9'd2;
    localparam period_t RST_TRIG_PERIOD  = 22'd100000;
    localparam div_t    RST_TICKS_PER_CM = 16'd58;

endpackage

`default_nettype wire

// ===== rtl/core/ultrasonic_echo_ranging_core.sv =====
// channel   direction  valid / stall           payload
// in        sink       in_valid / in_stall     echo_level
// out       source     out_valid / out_stall   trigger_level, distance_cm,
//                                              measurement_done, out_of_range
// cfg       apb        psel, penable, pwrite   paddr, pwdata, prdata
//
// One tick transaction per cycle while in_stall is low; its result is registered and shows in the next cycle.
// Latency and rate are set by the single result register after the tick logic.
// in_stall is high only while a result waits and out_stall is high.
// Reset (rst_n low, asynchronous) loads register defaults and clears all ranging state.
`default_nettype none

module ultrasonic_echo_ranging_core
#(
    parameter int unsigned MAX_RANGE_CM        = 400,
    parameter int unsigned TRIGGER_PULSE_TICKS = 10
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      echo_level,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           trigger_level,
    output uer_pkg::dist_t                 distance_cm,
    output logic                           measurement_done,
    output logic                           out_of_range,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [uer_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    import uer_pkg::*;

    localparam dist_t   CM_SAT     = DIST_W'(MAX_RANGE_CM + 1);
    localparam dist_t   CM_MAX     = DIST_W'(MAX_RANGE_CM);
    localparam period_t PULSE_TICKS = PERIOD_W'(TRIGGER_PULSE_TICKS);

    logic    enable_reg;
    dist_t   noise_thr_reg;
    period_t trig_period_reg;
    div_t    ticks_per_cm_reg;

    logic    echo_prev_reg,  echo_prev_next;
    dist_t   cm_reg,         cm_next;
    div_t    sub_reg,        sub_next;
    dist_t   reported_reg,   reported_next;
    period_t period_reg,     period_next;
    logic    over_reg,       over_next;

    logic    out_valid_reg;
    logic    trig_out_reg,   trig_next;
    dist_t   dist_out_reg;
    logic    done_out_reg,   done_next;
    logic    over_out_reg;

    logic            accept;
    logic            cfg_write;
    reg_idx_t        cfg_idx;
    logic [PERIOD_W:0] period_inc;
    logic [DIV_W:0]  sub_inc;
    div_t            divisor;
    logic            rising;
    dist_t           cm_base;
    div_t            sub_base;
    dist_t           diff;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE:       prdata = {31'd0, enable_reg};
            REG_NOISE_THR:    prdata = {{(32-DIST_W){1'b0}}, noise_thr_reg};
            REG_TRIG_PERIOD:  prdata = {{(32-PERIOD_W){1'b0}}, trig_period_reg};
            REG_TICKS_PER_CM: prdata = {{(32-DIV_W){1'b0}}, ticks_per_cm_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            noise_thr_reg    <= RST_NOISE_THR;
            trig_period_reg  <= RST_TRIG_PERIOD;
            ticks_per_cm_reg <= RST_TICKS_PER_CM;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ENABLE:       enable_reg       <= pwdata[0];
                REG_NOISE_THR:    noise_thr_reg    <= pwdata[DIST_W-1:0];
                REG_TRIG_PERIOD:  trig_period_reg  <= pwdata[PERIOD_W-1:0];
                REG_TICKS_PER_CM: ticks_per_cm_reg <= pwdata[DIV_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        divisor    = (ticks_per_cm_reg == '0) ? DIV_W'(1) : ticks_per_cm_reg;
        period_inc = {1'b0, period_reg} + 1'b1;
        rising     = echo_level && !echo_prev_reg;
        cm_base    = rising ? '0 : cm_reg;
        sub_base   = rising ? '0 : sub_reg;
        sub_inc    = {1'b0, sub_base} + 1'b1;
        diff       = (cm_reg > reported_reg) ? (cm_reg - reported_reg)
                                             : (reported_reg - cm_reg);

        echo_prev_next = echo_prev_reg;
        cm_next        = cm_reg;
        sub_next       = sub_reg;
        reported_next  = reported_reg;
        period_next    = period_reg;
        over_next      = over_reg;
        trig_next      = 1'b0;
        done_next      = 1'b0;

        if (!enable_reg)
        begin
            period_next    = '0;
            echo_prev_next = 1'b0;
            cm_next        = '0;
            sub_next       = '0;
        end
        else
        begin
            trig_next   = period_reg < PULSE_TICKS;
            period_next = (period_inc >= {1'b0, trig_period_reg}) ? '0
                                                                  : period_inc[PERIOD_W-1:0];
            if (echo_level)
            begin
                if (sub_inc >= {1'b0, divisor})
                begin
                    sub_next = '0;
                    cm_next  = (cm_base < CM_SAT) ? cm_base + 1'b1 : cm_base;
                end
                else
                begin
                    sub_next = sub_inc[DIV_W-1:0];
                    cm_next  = cm_base;
                end
            end
            else if (echo_prev_reg)
            begin
                over_next = cm_reg > CM_MAX;
                if (diff > noise_thr_reg)
                begin
                    reported_next = cm_reg;
                end
                done_next = 1'b1;
            end
            echo_prev_next = echo_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_prev_reg <= 1'b0;
            cm_reg        <= '0;
            sub_reg       <= '0;
            reported_reg  <= '0;
            period_reg    <= '0;
            over_reg      <= 1'b0;
        end
        else if (accept)
        begin
            echo_prev_reg <= echo_prev_next;
            cm_reg        <= cm_next;
            sub_reg       <= sub_next;
            reported_reg  <= reported_next;
            period_reg    <= period_next;
            over_reg      <= over_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            trig_out_reg <= trig_next;
            dist_out_reg <= reported_next;
            done_out_reg <= done_next;
            over_out_reg <= over_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign trigger_level    = trig_out_reg;
    assign distance_cm      = dist_out_reg;
    assign measurement_done = done_out_reg;
    assign out_of_range     = over_out_reg;

`include "ultrasonic_echo_ranging_core_assert.svh"

    `UER_ASSERT_ALWAYS(a_cm_saturated, cm_reg <= CM_SAT, "centimetre count above saturation")
    `UER_ASSERT_NEXT(a_disabled_clears, accept && !enable_reg,
                     period_reg == '0 && cm_reg == '0 && sub_reg == '0, "disabled tick kept state")
    `UER_ASSERT_ALWAYS(a_stall_needs_result, !in_stall || out_valid_reg,
                       "input stalled with no result waiting")

endmodule

`default_nettype wire

// ===== tb/ultrasonic_echo_ranging_core_test.sv =====
`timescale 1ns / 1ps

module ultrasonic_echo_ranging_core_test;
    import uer_pkg::*;

    localparam int unsigned RANGE_LIMIT_CM = 400;
    localparam int unsigned PULSE_TICKS    = 10;

    typedef struct packed {
        logic  trig;
        dist_t dist_cm;
        logic  done;
        logic  oor;
    } reading_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        reg_idx_t    idx;
        logic [31:0] value;
        logic        echo;
        logic        typed;
        reading_t    want;
    } plan_row_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  echo_level = 1'b0;
    logic                  out_stall  = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [ADDR_W-1:0]     paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic                  trigger_level;
    dist_t                 distance_cm;
    logic                  measurement_done;
    logic                  out_of_range;
    logic [31:0]           prdata;
    logic                  pready;

    logic                  cfg_enable = 1'b0;
    dist_t                 cfg_noise  = RST_NOISE_THR;
    period_t               cfg_period = RST_TRIG_PERIOD;
    div_t                  cfg_tpc    = RST_TICKS_PER_CM;
    logic                  echo_last      = 1'b0;
    dist_t                 cm_count       = '0;
    div_t                  sub_count      = '0;
    dist_t                 shown_distance = '0;
    period_t               trig_phase     = '0;
    logic                  over_range     = 1'b0;

    reading_t              pending_readings[$];
    plan_row_t             stimulus_plan[$];
    int unsigned           sender_idle_pct = 0;
    int unsigned           recv_stall_pct  = 0;
    int unsigned           mismatches      = 0;

    ultrasonic_echo_ranging_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .echo_level       (echo_level),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .trigger_level    (trigger_level),
        .distance_cm      (distance_cm),
        .measurement_done (measurement_done),
        .out_of_range     (out_of_range),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 clk = ~clk;

    function automatic reading_t range_tick(input logic level);
        reading_t    r;
        int unsigned divisor;
        int unsigned raw;
        int unsigned gap;
        r = '0;
        if (!cfg_enable)
        begin
            trig_phase = '0;
            echo_last  = 1'b0;
            cm_count   = '0;
            sub_count  = '0;
        end
        else
        begin
            divisor = (cfg_tpc == 0) ? 1 : int'(cfg_tpc);
            r.trig  = (int'(trig_phase) < PULSE_TICKS);
            if (int'(trig_phase) + 1 >= int'(cfg_period))
                trig_phase = '0;
            else
                trig_phase = trig_phase + 1'b1;
            if (level)
            begin
                if (!echo_last)
                begin
                    cm_count  = '0;
                    sub_count = '0;
                end
                if (int'(sub_count) + 1 >= divisor)
                begin
                    sub_count = '0;
                    if (int'(cm_count) < RANGE_LIMIT_CM + 1)
                        cm_count = cm_count + 1'b1;
                end
                else
                    sub_count = sub_count + 1'b1;
            end
            else if (echo_last)
            begin
                raw = cm_count;
                gap = (raw > shown_distance) ? raw - shown_distance : shown_distance - raw;
                over_range = (raw > RANGE_LIMIT_CM);
                if (gap > cfg_noise)
                    shown_distance = cm_count;
                r.done = 1'b1;
            end
            echo_last = level;
        end
        r.dist_cm = shown_distance;
        r.oor     = over_range;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : watch_results
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("result with no transaction pending", 1, 0);
            else
            begin
                want = pending_readings.pop_front();
                if (trigger_level !== want.trig)
                    report_mismatch("trigger_level", trigger_level, want.trig);
                if (distance_cm !== want.dist_cm)
                    report_mismatch("distance_cm", distance_cm, want.dist_cm);
                if (measurement_done !== want.done)
                    report_mismatch("measurement_done", measurement_done, want.done);
                if (out_of_range !== want.oor)
                    report_mismatch("out_of_range", out_of_range, want.oor);
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_tick(input logic level, input logic typed, input reading_t want);
        reading_t r;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        echo_level <= level;
        do @(posedge clk); while (in_stall);
        r = range_tick(level);
        pending_readings.push_back(typed ? want : r);
    endtask

    task automatic send_run(input logic level, input int unsigned count);
        repeat (count) send_tick(level, 1'b0, '0);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ENABLE:       cfg_enable = value[0];
            REG_NOISE_THR:    cfg_noise  = value[DIST_W-1:0];
            REG_TRIG_PERIOD:  cfg_period = value[PERIOD_W-1:0];
            REG_TICKS_PER_CM: cfg_tpc    = value[DIV_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic add_tick(input logic level);
        stimulus_plan.push_back('{ROW_TICK, REG_ENABLE, 32'd0, level, 1'b0, reading_t'(0)});
    endtask

    task automatic add_check(input logic level, input logic trig, input int unsigned dist_cm,
                             input logic done, input logic oor);
        reading_t want;
        want = '{trig, dist_t'(dist_cm), done, oor};
        stimulus_plan.push_back('{ROW_TICK, REG_ENABLE, 32'd0, level, 1'b1, want});
    endtask

    task automatic add_write(input reg_idx_t idx, input logic [31:0] value);
        stimulus_plan.push_back('{ROW_WRITE, idx, value, 1'b0, 1'b0, reading_t'(0)});
    endtask

    task automatic run_phase(input logic en, input int unsigned noise, input int unsigned period,
                             input int unsigned tpc, input int unsigned idle_pct,
                             input int unsigned stall_pct, input int unsigned count,
                             input logic long_pulse);
        int unsigned sent;
        int unsigned lo_len;
        int unsigned hi_len;
        wait_idle();
        write_reg(REG_NOISE_THR, noise);
        write_reg(REG_TRIG_PERIOD, period);
        write_reg(REG_TICKS_PER_CM, tpc);
        write_reg(REG_ENABLE, {31'd0, en});
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        sent = 0;
        if (long_pulse)
        begin
            hi_len = $urandom_range(410, 398);
            send_run(1'b0, 2);
            send_run(1'b1, hi_len);
            send_run(1'b0, 1);
            sent = hi_len + 3;
        end
        while (sent < count)
        begin
            if ($urandom_range(99) < 85)
            begin
                lo_len = $urandom_range(5, 1);
                hi_len = $urandom_range(24, 1);
                send_run(1'b0, lo_len);
                send_run(1'b1, hi_len);
                sent += lo_len + hi_len;
            end
            else
            begin
                lo_len = $urandom_range(4, 1);
                repeat (lo_len) send_tick($urandom_range(1), 1'b0, '0);
                sent += lo_len;
            end
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("ultrasonic_echo_ranging_core_test failed");
        $finish;
    end

    initial
    begin
        // disabled after reset: echo ignored, outputs at rest
        add_check(1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_check(1'b1, 1'b0, 0, 1'b0, 1'b0);
        add_write(REG_NOISE_THR, 0);
        add_write(REG_TRIG_PERIOD, 20);
        add_write(REG_TICKS_PER_CM, 1);
        add_write(REG_ENABLE, 1);
        add_check(1'b0, 1'b1, 0, 1'b0, 1'b0);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b0);
        // zero divisor counts as one
        add_write(REG_TICKS_PER_CM, 0);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b0);
        // wide deadband holds the reported distance
        add_write(REG_NOISE_THR, 401);
        repeat (5) add_tick(1'b1);
        add_tick(1'b0);
        add_write(REG_NOISE_THR, 511);
        // enable while echo is already high
        add_write(REG_ENABLE, 0);
        add_tick(1'b1);
        add_write(REG_ENABLE, 1);
        add_tick(1'b1);
        add_tick(1'b0);
        // short periods hold the trigger high
        add_write(REG_NOISE_THR, 0);
        add_write(REG_TRIG_PERIOD, 1);
        add_tick(1'b0);
        add_tick(1'b0);
        add_write(REG_TRIG_PERIOD, 0);
        add_tick(1'b0);
        add_write(REG_TRIG_PERIOD, 4194303);
        add_write(REG_TICKS_PER_CM, 65535);
        add_tick(1'b1);
        add_tick(1'b0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stimulus_plan[i])
        begin
            if (stimulus_plan[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(stimulus_plan[i].idx, stimulus_plan[i].value);
            end
            else
                send_tick(stimulus_plan[i].echo, stimulus_plan[i].typed, stimulus_plan[i].want);
        end

        run_phase(1'b1, 0, 20, 1, 0, 0, 120, 1'b0);
        run_phase(1'b1, 2, 37, 3, 60, 0, 120, 1'b0);
        run_phase(1'b1, 5, 20, 2, 0, 60, 120, 1'b0);
        run_phase(1'b1, 1, 4194303, 1, 38, 38, 60, 1'b1);
        run_phase(1'b0, 3, 25, 1, 38, 38, 40, 1'b0);
        run_phase(1'b1, 0, 1, 4, 0, 0, 80, 1'b0);
        run_phase(1'b1, 10, 64, 2, 60, 0, 60, 1'b0);
        run_phase(1'b1, 0, 0, 1, 38, 38, 60, 1'b0);

        wait_idle();
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("ultrasonic_echo_ranging_core_test passed");
        else
            $display("ultrasonic_echo_ranging_core_test failed");
        $finish;
    end

endmodule
